// ----- design/mpq_pkg.sv -----
// mpq_pkg: shared types, constants and the entry ordering function for the
// max priority queue. No dependencies; used by mpq_cell and max_priority_queue.
package mpq_pkg;

	localparam int DEPTH = 128;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int VALUE_W = 32;
	localparam int PRIO_W = 16;
	localparam int OP_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 8;

	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// command broadcast to every cell in the chain
	typedef struct packed {
		logic ins;
		logic shift;
		entry_t item;
	} cell_cmd_t;

	// a is served before b: higher priority, then larger signed value
	function automatic logic entry_gt(input entry_t a, input entry_t b);
		logic [PRIO_W+VALUE_W-1:0] ka;
		logic [PRIO_W+VALUE_W-1:0] kb;
		ka = {a.prio, ~a.value[VALUE_W-1], a.value[VALUE_W-2:0]};
		kb = {b.prio, ~b.value[VALUE_W-1], b.value[VALUE_W-2:0]};
		return ka > kb;
	endfunction

endpackage

// ----- design/max_priority_queue.sv -----
// Bounded max priority queue of DEPTH entries, each a signed value and an
// unsigned priority. Each item enqueues, dequeues the top entry, or peeks at it,
// and gives exactly one result item. An item is first registered; once the output
// register can take its result, the whole chain of cells inserts or shifts in parallel.
// The chain is kept sorted, so the top entry always sits in the first cell; no
// scan and no clearing pass after reset. A new item is accepted while the
// previous result waits in the output register. Depends on mpq_pkg, mpq_cell.
module max_priority_queue
	import mpq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[1:0], item_value[33:2], item_priority[49:34], zero fill
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], top_value[33:2], top_priority[49:34], entry_count[57:50], zero fill
	output logic [63:0] m_axis_tdata
);

	logic busy_q;
	logic [OP_W-1:0] op_s1;
	entry_t item_s1;
	logic [CNT_W-1:0] count_q;

	logic out_valid_q;
	logic [STATUS_W-1:0] status_q;
	entry_t top_q;
	logic [COUNT_OUT_W-1:0] count_out_q;

	logic exec;
	logic full;
	logic empty;
	cell_cmd_t cmd;
	entry_t cell_entry [DEPTH];
	logic cell_beat [DEPTH];
	logic [CNT_W-1:0] count_next;
	logic [STATUS_W-1:0] status_next;
	entry_t top_next;

	assign s_axis_tready = !busy_q;
	assign exec = busy_q && (!out_valid_q || m_axis_tready);
	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign cmd.ins = exec && (op_s1 == OP_ENQUEUE) && !full;
	assign cmd.shift = exec && (op_s1 == OP_DEQUEUE) && !empty;
	assign cmd.item = item_s1;

	always_comb begin
		count_next = count_q;
		status_next = ST_OK;
		top_next = '0;
		case (op_s1)
			OP_ENQUEUE: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_DEQUEUE, OP_PEEK: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					top_next = cell_entry[0];
					if (op_s1 == OP_DEQUEUE) begin
						count_next = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		entry_t prev_e;
		entry_t next_e;
		logic prev_b;
		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_b = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_entry[i-1];
			assign prev_b = cell_beat[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_e = cell_entry[i];
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end
		mpq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (IDX < count_q),
			.prev_beat  (prev_b),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.beat       (cell_beat[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				count_q <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1 <= s_axis_tdata[1:0];
			item_s1.value <= s_axis_tdata[33:2];
			item_s1.prio <= s_axis_tdata[49:34];
		end
		if (exec) begin
			status_q <= status_next;
			top_q <= top_next;
			count_out_q <= count_next[COUNT_OUT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'd0, count_out_q, top_q.prio, top_q.value, status_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> busy_q && !s_axis_tready)
		else $error("accepted item not held for execution");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("dequeue did not drop the count");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("enqueue did not raise the count");

	a_top_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> !entry_gt(cell_entry[1], cell_entry[0]))
		else $error("first cell does not hold the top entry");

endmodule

// ----- design/mpq_cell.sv -----
// mpq_cell: one slot of the sorted chain; holds one entry and trades it with
// its neighbors on insert and on removal of the top. Depends on mpq_pkg.
module mpq_cell
	import mpq_pkg::*;
(
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  logic      occupied,
	input  logic      prev_beat,
	input  entry_t    prev_entry,
	input  entry_t    next_entry,
	output entry_t    entry,
	output logic      beat
);

	entry_t entry_q;

	// the new item goes at or above this slot
	assign beat = !occupied || entry_gt(cmd.item, entry_q);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_beat) begin
				entry_q <= prev_entry;
			end else if (beat) begin
				entry_q <= cmd.item;
			end
		end else if (cmd.shift) begin
			entry_q <= next_entry;
		end
	end

endmodule
